>>> rtl/core/kmd_pkg.sv
// Shared types, constants and helpers for the key matrix debouncer.
package kmd_pkg;

    // Field widths
    localparam int ROW_IDX_W  = 3;
    localparam int FIELD_W    = 16;
    localparam int ELAPSED_W  = 8;
    localparam int TIMER_W    = 7;
    localparam int DELAY_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int ROW_EXT_W  = 6;

    // Input beat layout (row, raw, elapsed), padded to 32 bits
    localparam int IN_ROW_LSB = 0;
    localparam int IN_RAW_LSB = IN_ROW_LSB + ROW_IDX_W;
    localparam int IN_EL_LSB  = IN_RAW_LSB + FIELD_W;
    localparam int IN_USED_W  = IN_EL_LSB + ELAPSED_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // Output beat layout (cooked, changed), padded to 24 bits
    localparam int OUT_USED_W  = FIELD_W + 1;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Parameter defaults
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 16;

    localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(5);

    typedef enum logic [1:0] {
        MODE_DEFER = 2'd0,
        MODE_EAGER = 2'd1,
        MODE_ASYM  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 2'd0,
        CFG_PRESS   = 2'd1,
        CFG_RELEASE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_mode               mode;
        logic [DELAY_W-1:0]  press;
        logic [DELAY_W-1:0]  release_d;
    } t_lane_cfg;

    typedef struct packed {
        logic                press_flag;
        logic [TIMER_W-1:0]  timer;
    } t_key_state;

    typedef struct packed {
        logic accept;
        logic row_ok;
    } t_merge_ctl;

    // Reserved mode code falls back to deferred
    function automatic t_mode mode_decode(input logic [CFG_DATA_W-1:0] v);
        t_mode m;
        if (v[1:0] == MODE_EAGER) begin
            m = MODE_EAGER;
        end else if (v[1:0] == MODE_ASYM) begin
            m = MODE_ASYM;
        end else begin
            m = MODE_DEFER;
        end
        return m;
    endfunction

    // Zero delay is taken as 1 ms
    function automatic logic [DELAY_W-1:0] fix_delay(input logic [CFG_DATA_W-1:0] v);
        logic [DELAY_W-1:0] d;
        d = DELAY_W'(v);
        return (d == '0) ? DELAY_W'(1) : d;
    endfunction

endpackage

>>> rtl/core/kmd_lane.sv
// One key lane: timer countdown and mode-specific debounce of a single column.
module kmd_lane
    import kmd_pkg::*;
(
    input  t_lane_cfg              i_cfg,
    input  logic                   i_raw,
    input  logic                   i_cooked,
    input  t_key_state             i_state,
    input  logic [ELAPSED_W-1:0]   i_elapsed,
    output logic                   o_cooked,
    output t_key_state             o_state
);

    logic               w_tc_cooked;
    logic [TIMER_W-1:0] w_tc_timer;
    logic               w_diff;

    // timer phase
    always_comb begin
        w_tc_cooked = i_cooked;
        w_tc_timer  = i_state.timer;
        if (i_state.timer != '0) begin
            if ({1'b0, i_state.timer} <= i_elapsed) begin
                w_tc_timer = '0;
                if (i_cfg.mode == MODE_DEFER ||
                    (i_cfg.mode == MODE_ASYM && !i_state.press_flag)) begin
                    w_tc_cooked = i_raw;
                end
            end else begin
                w_tc_timer = TIMER_W'({1'b0, i_state.timer} - i_elapsed);
            end
        end
    end

    assign w_diff = i_raw ^ w_tc_cooked;

    // transfer phase
    always_comb begin
        o_cooked           = w_tc_cooked;
        o_state.timer      = w_tc_timer;
        o_state.press_flag = i_state.press_flag;
        unique case (i_cfg.mode)
            MODE_EAGER: begin
                if (w_diff && w_tc_timer == '0) begin
                    o_state.timer = i_cfg.release_d;
                    o_cooked      = ~w_tc_cooked;
                end
            end
            MODE_ASYM: begin
                if (w_diff) begin
                    if (w_tc_timer == '0) begin
                        o_state.press_flag = i_raw;
                        o_state.timer      = i_raw ? i_cfg.press : i_cfg.release_d;
                        if (i_raw) begin
                            o_cooked = ~w_tc_cooked;
                        end
                    end
                end else if (w_tc_timer != '0 && !i_state.press_flag) begin
                    o_state.timer = '0;
                end
            end
            default: begin
                if (w_diff) begin
                    if (w_tc_timer == '0) begin
                        o_state.timer = i_cfg.press;
                    end
                end else begin
                    o_state.timer = '0;
                end
            end
        endcase
    end

endmodule

>>> rtl/core/kmd_merge.sv
// Merge stage: gathers lane results, flags a changed row, holds the output beat.
module kmd_merge
    import kmd_pkg::*;
#(
    parameter int LANES = COLS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_merge_ctl              i_ctl,
    input  logic [LANES-1:0]        i_new_bits,
    input  logic [LANES-1:0]        i_old_bits,
    input  logic                    i_m_tready,
    output logic                    o_ready,
    output logic                    o_m_tvalid,
    output logic [OUT_TDATA_W-1:0]  o_m_tdata
);

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    logic [OUT_TDATA_W-1:0] n_data;
    logic [FIELD_W-1:0]     w_cooked;
    logic                   w_changed;

    assign o_ready = !r_valid || i_m_tready;

    always_comb begin
        w_cooked  = '0;
        w_changed = 1'b0;
        if (i_ctl.row_ok) begin
            w_cooked  = FIELD_W'(i_new_bits);
            w_changed = (i_new_bits != i_old_bits);
        end
        n_data = OUT_TDATA_W'({w_changed, w_cooked});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.accept) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_data <= n_data;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

>>> rtl/core/key_matrix_debouncer_three_mode.sv
// Top level: per-key debouncer for a scanned key matrix, one row per beat.
// Output beat: registered in kmd_merge, valid in the cycle after the input beat is accepted.
// Throughput: 1 row per cycle while the output is not held back; all columns of a row run in
//   parallel lanes and the row state is read and written back in the same cycle, so rows may repeat.
// Reset (sync, active low): mode deferred, both delays 5 ms, all timers, press
//   flags and debounced rows cleared; output empty.
module key_matrix_debouncer_three_mode
    import kmd_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // input beat
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [IN_TDATA_W-1:0]   i_s_tdata,   // row_index[2:0], raw_bits[18:3], elapsed_ms[26:19]
    // output beat
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_tdata    // cooked_bits[15:0], row_changed[16]
);

    // Columns beyond the 16-bit row field are never looked at.
    localparam int LANES = (COLS < FIELD_W) ? COLS : FIELD_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // config registers
    t_mode              r_mode;
    logic [DELAY_W-1:0] r_press;
    logic [DELAY_W-1:0] r_release;

    // per-row state: debounced bits plus one timer/flag per lane
    logic [LANES-1:0]   r_rows  [ROWS];
    t_key_state         r_state [ROWS][LANES];

    logic [ROW_IDX_W-1:0] w_row;
    logic [FIELD_W-1:0]   w_raw;
    logic [ELAPSED_W-1:0] w_elapsed;
    logic [ROW_EXT_W-1:0] w_row_ext;
    logic [ROW_W-1:0]     w_sel;
    logic                 w_row_ok;
    logic                 w_acc;
    logic                 w_cfg_hit;

    t_lane_cfg            w_lane_cfg;
    logic [LANES-1:0]     w_old_bits;
    logic [LANES-1:0]     w_new_bits;
    t_key_state           w_lane_state [LANES];
    t_merge_ctl           w_ctl;

    // unpack the input beat
    assign w_row     = i_s_tdata[IN_RAW_LSB-1:IN_ROW_LSB];
    assign w_raw     = i_s_tdata[IN_EL_LSB-1:IN_RAW_LSB];
    assign w_elapsed = i_s_tdata[IN_USED_W-1:IN_EL_LSB];
    assign w_row_ext = ROW_EXT_W'(w_row);
    assign w_sel     = w_row_ext[ROW_W-1:0];
    // out-of-range rows leave state alone and give an all-zero result
    assign w_row_ok  = (w_row_ext < ROW_EXT_W'(ROWS));
    assign w_acc     = i_s_tvalid && o_s_tready;

    // any write to a defined register clears every timer and press flag
    assign w_cfg_hit = i_cfg_we && (i_cfg_idx == CFG_MODE || i_cfg_idx == CFG_PRESS ||
                                    i_cfg_idx == CFG_RELEASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_DEFER;
            r_press   <= DELAY_RST;
            r_release <= DELAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:    r_mode    <= mode_decode(i_cfg_data);
                CFG_PRESS:   r_press   <= fix_delay(i_cfg_data);
                CFG_RELEASE: r_release <= fix_delay(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign w_lane_cfg = '{mode: r_mode, press: r_press, release_d: r_release};
    assign w_old_bits = r_rows[w_sel];

    // one lane per column, up to the 16-bit row field
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        kmd_lane u_lane (
            .i_cfg     (w_lane_cfg),
            .i_raw     (w_raw[l]),
            .i_cooked  (w_old_bits[l]),
            .i_state   (r_state[w_sel][l]),
            .i_elapsed (w_elapsed),
            .o_cooked  (w_new_bits[l]),
            .o_state   (w_lane_state[l])
        );
    end

    // state write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_state[r][l] <= '0;
                end
            end
        end else if (w_acc && w_row_ok) begin
            for (int l = 0; l < LANES; l++) begin
                r_state[w_sel][l] <= w_lane_state[l];
            end
        end
    end

    // debounced rows survive config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_rows[r] <= '0;
            end
        end else if (w_acc && w_row_ok) begin
            r_rows[w_sel] <= w_new_bits;
        end
    end

    assign w_ctl = '{accept: w_acc, row_ok: w_row_ok};

    kmd_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_new_bits (w_new_bits),
        .i_old_bits (w_old_bits),
        .i_m_tready (i_m_tready),
        .o_ready    (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    // checks
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output beat present after reset");

    a_acc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_m_tvalid)
        else $error("accepted row produced no output beat");

    a_bad_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_row_ok) |=> (o_m_tdata == '0))
        else $error("out-of-range row gave a nonzero result");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0))
        else $error("output padding bits not zero");

endmodule
